// ===== hw/rtl/ohtt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohtt_pkg
// Shared types and constants of the ordered hash table with tombstones.
// ----------------------------------------------------------------------------
package ohtt_pkg;

  // Table geometry; the home slot is the hash reduced to the low address bits.
  localparam int SLOTS    = 1024;
  localparam int ADDR_W   = $clog2(SLOTS);
  localparam int IDX_W    = ADDR_W + 1;
  localparam int KEY_W    = 64;
  localparam int TOMB_W   = 10;
  localparam int HOPS_W   = 13;
  localparam logic [HOPS_W-1:0] HOPS_MAX = 13'd4096;

  // Hash constants.
  localparam logic [63:0] MUR_M    = 64'hc6a4a7935bd1e995;
  localparam logic [63:0] SEED_MIX = MUR_M << 3;
  localparam int          MUR_R    = 47;

  // Operation codes.
  typedef enum logic [1:0] {
    CMD_QUERY  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_e;

  // One table entry.
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [ADDR_W-1:0] home;
  } entry_t;

  // A hashed request on its way from the front end to the executor.
  typedef struct packed {
    logic [1:0]        cmd;
    logic [KEY_W-1:0]  key;
    logic [ADDR_W-1:0] home;
  } req_t;

  // Front end states.
  typedef enum logic [1:0] {
    FS_IDLE,
    FS_HASH,
    FS_PUSH
  } front_state_e;

  // Executor states.
  typedef enum logic [4:0] {
    XS_INIT,
    XS_IDLE,
    XS_FRD,
    XS_FEV,
    XS_DEL,
    XS_RRD,
    XS_REV,
    XS_IRD,
    XS_IEV,
    XS_IPUT,
    XS_TRD,
    XS_TCUR,
    XS_TNX,
    XS_TEV,
    XS_LRD,
    XS_LMV,
    XS_LPUT,
    XS_DONE
  } exec_state_e;

endpackage

// ===== hw/rtl/ohtt_hash.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohtt_hash
// Front end: accepts requests and computes the home slot with a shared
// 32x32 multiplier, four 64-bit products of three partial products each.
// ----------------------------------------------------------------------------
module ohtt_hash (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            cmd_i,
  input  logic [63:0]           key_i,
  input  logic                  init_done_i,
  output logic                  req_valid_o,
  input  logic                  req_ready_i,
  output ohtt_pkg::req_t        req_o
);
  import ohtt_pkg::*;

  front_state_e state_q, state_d;
  logic [1:0]   step_q, step_d;
  logic [1:0]   round_q, round_d;
  logic [63:0]  a_q, a_d;
  logic [63:0]  acc_q, acc_d;
  logic [63:0]  prod_q, prod_d;
  req_t         req_q, req_d;
  logic [31:0]  mul_a, mul_b;
  logic [63:0]  res, mixed;

  // Operand selection for the low 64 bits of a * MUR_M.
  always_comb begin
    case (step_q)
      2'd0:    begin mul_a = a_q[31:0];  mul_b = MUR_M[31:0];  end
      2'd1:    begin mul_a = a_q[31:0];  mul_b = MUR_M[63:32]; end
      default: begin mul_a = a_q[63:32]; mul_b = MUR_M[31:0];  end
    endcase
  end

  assign res   = acc_q + {prod_q[31:0], 32'd0};
  assign mixed = res ^ (res >> MUR_R);

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
      step_q  <= '0;
      round_q <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      round_q <= round_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    req_q  <= req_d;
  end

  // Next state and datapath control.
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    round_d     = round_q;
    a_d         = a_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    req_d       = req_q;
    in_ready_o  = 1'b0;
    req_valid_o = 1'b0;
    unique case (state_q)
      FS_IDLE: begin
        in_ready_o = init_done_i;
        if (in_valid_i && init_done_i) begin
          req_d.cmd  = cmd_i;
          req_d.key  = key_i;
          a_d        = key_i;
          step_d     = '0;
          round_d    = '0;
          state_d    = FS_HASH;
        end
      end
      FS_HASH: begin
        step_d = step_q + 2'd1;
        if (step_q != 2'd3) begin
          prod_d = 64'(mul_a) * 64'(mul_b);
        end
        case (step_q)
          2'd0:    ;
          2'd1:    acc_d = prod_q;
          2'd2:    acc_d = res;
          default: begin
            // Finish one product and apply the mixing that follows it.
            round_d = round_q + 2'd1;
            case (round_q)
              2'd1:    a_d = SEED_MIX ^ res;
              2'd3:    begin
                req_d.home = mixed[ADDR_W-1:0];
                state_d    = FS_PUSH;
              end
              default: a_d = mixed;
            endcase
          end
        endcase
      end
      FS_PUSH: begin
        req_valid_o = 1'b1;
        if (req_ready_i) begin
          state_d = FS_IDLE;
        end
      end
      default: state_d = FS_IDLE;
    endcase
  end

  assign req_o = req_q;

endmodule

// ===== hw/rtl/ohtt_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohtt_queue
// Two-entry request queue between the hash front end and the executor.
// ----------------------------------------------------------------------------
module ohtt_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  ohtt_pkg::req_t  push_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output ohtt_pkg::req_t  pop_o
);
  import ohtt_pkg::*;

  req_t       buf_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_o        = buf_q[rd_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) buf_q[wr_q] <= push_i;
  end

endmodule

// ===== hw/rtl/ohtt_exec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohtt_exec
// Back end: owns the slot memory and carries out query, insert and delete
// one slot access at a time, with a result register toward the output.
// ----------------------------------------------------------------------------
module ohtt_exec (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           req_valid_i,
  output logic                           req_ready_o,
  input  ohtt_pkg::req_t                 req_i,
  input  logic                           cfg_we_i,
  input  logic [ohtt_pkg::TOMB_W-1:0]    cfg_wdata_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           found_o,
  output logic [ohtt_pkg::HOPS_W-1:0]    hops_o,
  output logic                           status_o,
  output logic                           init_done_o
);
  import ohtt_pkg::*;

  // Slot memory.
  entry_t             mem_q [SLOTS];
  entry_t             rdata_q;
  logic [ADDR_W-1:0]  rd_addr;
  logic               we;
  logic [ADDR_W-1:0]  waddr;
  entry_t             wdata;

  exec_state_e        state_q, state_d;
  logic [TOMB_W-1:0]  tomb_q;
  logic               out_valid_q, out_valid_d;
  logic               out_found_q, out_found_d;
  logic [HOPS_W-1:0]  out_hops_q, out_hops_d;
  logic               out_status_q, out_status_d;

  logic [1:0]         cmd_q, cmd_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [ADDR_W-1:0]  home_q, home_d;
  logic [IDX_W-1:0]   i_q, i_d;
  logic [IDX_W-1:0]   j_q, j_d;
  logic [ADDR_W-1:0]  gap_q, gap_d;
  logic [ADDR_W-1:0]  ind_q, ind_d;
  entry_t             carry_q, carry_d;
  logic               carrying_q, carrying_d;
  logic               have_run_q, have_run_d;
  logic [ADDR_W-1:0]  run_home_q, run_home_d;
  entry_t             cur_q, cur_d;
  logic [HOPS_W-1:0]  hops_q, hops_d;
  logic               found_q, found_d;
  logic               status_q, status_d;

  logic [IDX_W-1:0]   i_nxt, j_nxt, j_prev;
  logic               has_next, out_free, rd_empty, rd_tomb, cur_tomb;
  entry_t             nxt;
  logic [ADDR_W-1:0]  rh_eff;

  localparam logic [KEY_W-1:0] KEY_ONES = '1;
  localparam logic [IDX_W-1:0] SLOTS_I  = IDX_W'(SLOTS);

  assign i_nxt    = i_q + 1'b1;
  assign j_nxt    = j_q + 1'b1;
  assign j_prev   = j_q - 1'b1;
  assign has_next = (j_nxt < SLOTS_I);
  assign nxt      = has_next ? rdata_q : '0;
  assign rd_empty = (rdata_q.key == '0);
  assign rd_tomb  = (rdata_q.key == KEY_ONES);
  assign cur_tomb = (cur_q.key == KEY_ONES);
  assign rh_eff   = have_run_q ? run_home_q : cur_q.home;
  assign out_free = !out_valid_q || out_ready_i;

  // Memory: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rdata_q <= mem_q[rd_addr];
  end

  // Read address follows the state.
  always_comb begin
    unique case (state_q)
      XS_TRD:          rd_addr = j_q[ADDR_W-1:0];
      XS_TCUR, XS_TNX: rd_addr = j_nxt[ADDR_W-1:0];
      XS_LRD:          rd_addr = j_prev[ADDR_W-1:0];
      default:         rd_addr = i_q[ADDR_W-1:0];
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= XS_INIT;
      tomb_q      <= '0;
      out_valid_q <= 1'b0;
      i_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      i_q         <= i_d;
      if (cfg_we_i) tomb_q <= cfg_wdata_i;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    out_found_q  <= out_found_d;
    out_hops_q   <= out_hops_d;
    out_status_q <= out_status_d;
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    home_q       <= home_d;
    j_q          <= j_d;
    gap_q        <= gap_d;
    ind_q        <= ind_d;
    carry_q      <= carry_d;
    carrying_q   <= carrying_d;
    have_run_q   <= have_run_d;
    run_home_q   <= run_home_d;
    cur_q        <= cur_d;
    hops_q       <= hops_d;
    found_q      <= found_d;
    status_q     <= status_d;
  end

  // Sequencer for the operations.
  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_found_d  = out_found_q;
    out_hops_d   = out_hops_q;
    out_status_d = out_status_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    home_d       = home_q;
    i_d          = i_q;
    j_d          = j_q;
    gap_d        = gap_q;
    ind_d        = ind_q;
    carry_d      = carry_q;
    carrying_d   = carrying_q;
    have_run_d   = have_run_q;
    run_home_d   = run_home_q;
    cur_d        = cur_q;
    hops_d       = hops_q;
    found_d      = found_q;
    status_d     = status_q;
    we           = 1'b0;
    waddr        = i_q[ADDR_W-1:0];
    wdata        = '0;
    req_ready_o  = 1'b0;

    unique case (state_q)
      // Clearing pass: every slot becomes empty.
      XS_INIT: begin
        we  = 1'b1;
        i_d = i_nxt;
        if (i_nxt == SLOTS_I) state_d = XS_IDLE;
      end

      // Take the next request and decode it.
      XS_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_d      = req_i.cmd;
          key_d      = req_i.key;
          home_d     = req_i.home;
          i_d        = {1'b0, req_i.home};
          hops_d     = '0;
          found_d    = 1'b0;
          status_d   = 1'b0;
          carrying_d = 1'b0;
          if (req_i.key == '0 || req_i.key == KEY_ONES) begin
            state_d = XS_DONE;
          end else begin
            unique case (req_i.cmd)
              CMD_QUERY, CMD_DELETE: state_d = XS_FRD;
              CMD_INSERT:            state_d = XS_RRD;
              default:               state_d = XS_DONE;
            endcase
          end
        end
      end

      // Lookup walk shared by query and delete.
      XS_FRD: state_d = XS_FEV;
      XS_FEV: begin
        if (rdata_q.key == key_q) begin
          if (cmd_q == CMD_DELETE) begin
            state_d = XS_DEL;
          end else begin
            found_d = 1'b1;
            state_d = XS_DONE;
          end
        end else if (rd_empty || (!rd_tomb && rdata_q.home > home_q)) begin
          state_d = XS_DONE;
        end else begin
          i_d     = i_nxt;
          state_d = (i_nxt == SLOTS_I) ? XS_DONE : XS_FRD;
        end
      end
      XS_DEL: begin
        we         = 1'b1;
        wdata.key  = KEY_ONES;
        wdata.home = ADDR_W'(tomb_q);
        state_d    = XS_DONE;
      end

      // Insert, first pass: look for room up to the table end.
      XS_RRD: state_d = XS_REV;
      XS_REV: begin
        if (rd_empty || rd_tomb) begin
          i_d     = {1'b0, home_q};
          state_d = XS_IRD;
        end else if (i_nxt == SLOTS_I) begin
          status_d = 1'b1;
          hops_d   = HOPS_W'(SLOTS_I - {1'b0, home_q});
          state_d  = XS_DONE;
        end else begin
          i_d     = i_nxt;
          state_d = XS_RRD;
        end
      end

      // Insert, main walk with the carried run head.
      XS_IRD: state_d = XS_IEV;
      XS_IEV: begin
        if (rd_empty || (rd_tomb && carrying_q)) begin
          we     = 1'b1;
          hops_d = hops_q + 1'b1;
          if (carrying_q) begin
            wdata   = carry_q;
            state_d = XS_IPUT;
          end else begin
            wdata.key  = key_q;
            wdata.home = home_q;
            state_d    = XS_DONE;
          end
        end else if (rd_tomb) begin
          // A tombstone opens a gap that travels forward.
          gap_d      = i_q[ADDR_W-1:0];
          j_d        = i_nxt;
          have_run_d = 1'b0;
          run_home_d = '0;
          state_d    = (i_nxt == SLOTS_I) ? XS_LRD : XS_TRD;
        end else begin
          if (!carrying_q && rdata_q.home > home_q) begin
            carrying_d = 1'b1;
            ind_d      = i_q[ADDR_W-1:0];
            carry_d    = rdata_q;
          end else if (carrying_q && rdata_q.home != carry_q.home) begin
            we      = 1'b1;
            wdata   = carry_q;
            carry_d = rdata_q;
          end
          hops_d = hops_q + 1'b1;
          i_d    = i_nxt;
          if (i_nxt == SLOTS_I) begin
            status_d = 1'b1;
            state_d  = XS_DONE;
          end else begin
            state_d = XS_IRD;
          end
        end
      end
      XS_IPUT: begin
        we         = 1'b1;
        waddr      = ind_q;
        wdata.key  = key_q;
        wdata.home = home_q;
        state_d    = XS_DONE;
      end

      // Gap walk: current slot in cur_q, the slot after it in the read data.
      XS_TRD:  state_d = XS_TCUR;
      XS_TCUR: begin
        cur_d   = rdata_q;
        state_d = XS_TEV;
      end
      XS_TNX:  state_d = XS_TEV;
      XS_TEV: begin
        waddr = gap_q;
        wdata = cur_q;
        if (!cur_tomb && (cur_q.key == '0 || cur_q.home > home_q)) begin
          hops_d  = hops_q + 1'b1;
          state_d = XS_LRD;
        end else begin
          if (cur_tomb) begin
            if (has_next && nxt.key != '0 && nxt.key != KEY_ONES && have_run_q &&
                nxt.home != run_home_q) begin
              we         = 1'b1;
              gap_d      = j_q[ADDR_W-1:0];
              run_home_d = nxt.home;
            end
          end else begin
            have_run_d = 1'b1;
            run_home_d = rh_eff;
            if (!has_next || nxt.home != rh_eff) begin
              we         = 1'b1;
              gap_d      = j_q[ADDR_W-1:0];
              run_home_d = nxt.home;
            end
          end
          hops_d  = hops_q + 1'b1;
          j_d     = j_nxt;
          cur_d   = nxt;
          state_d = has_next ? XS_TNX : XS_LRD;
        end
      end

      // Close the gap with the slot before the stop and place the new key.
      XS_LRD: state_d = XS_LMV;
      XS_LMV: begin
        we      = 1'b1;
        waddr   = gap_q;
        wdata   = rdata_q;
        state_d = XS_LPUT;
      end
      XS_LPUT: begin
        we         = 1'b1;
        waddr      = j_prev[ADDR_W-1:0];
        wdata.key  = key_q;
        wdata.home = home_q;
        state_d    = XS_DONE;
      end

      // Hand the result to the output register.
      XS_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_found_d  = found_q;
          out_hops_d   = (hops_q > HOPS_MAX) ? HOPS_MAX : hops_q;
          out_status_d = status_q;
          state_d      = XS_IDLE;
        end
      end

      default: state_d = XS_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = out_found_q;
  assign hops_o      = out_hops_q;
  assign status_o    = out_status_q;
  assign init_done_o = (state_q != XS_INIT);

endmodule

// ===== hw/rtl/ordered_hash_table_tombstones_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_hash_table_tombstones_unit
// Ordered linear-probing hash table of 1024 slots with tombstones.
// ----------------------------------------------------------------------------
// After reset the table runs a clearing pass, during which no request is
// accepted. Each request is then hashed in the front end (four 64-bit
// products, each built from three 32x32 partial products on one shared
// multiplier), queued, and carried out by the executor, which works on the
// slot memory (one write port, one registered read port) one slot at a
// time: a query or delete probes slot after slot, an insert first scans
// for room and then makes its shifting walk. Hashing of the next request
// overlaps the work of the current one, and the result register lets a new
// request start while an answer waits to be taken. The tombstone home
// register may be written only while the unit is idle.
// ----------------------------------------------------------------------------
module ordered_hash_table_tombstones_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    cmd_i,
  input  logic [63:0]                   key_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          found_o,
  output logic [ohtt_pkg::HOPS_W-1:0]   hops_o,
  output logic                          status_o,
  input  logic                          cfg_we_i,
  input  logic [ohtt_pkg::TOMB_W-1:0]   cfg_wdata_i
);
  import ohtt_pkg::*;

  req_t fq_req, qx_req;
  logic fq_valid, fq_ready, qx_valid, qx_ready, init_done;

  // Front end: accept and hash.
  ohtt_hash u_hash (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .key_i       (key_i),
    .init_done_i (init_done),
    .req_valid_o (fq_valid),
    .req_ready_i (fq_ready),
    .req_o       (fq_req)
  );

  // Queue between the two halves.
  ohtt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_i       (fq_req),
    .pop_valid_o  (qx_valid),
    .pop_ready_i  (qx_ready),
    .pop_o        (qx_req)
  );

  // Back end: table operations.
  ohtt_exec u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (qx_valid),
    .req_ready_o (qx_ready),
    .req_i       (qx_req),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .found_o     (found_o),
    .hops_o      (hops_o),
    .status_o    (status_o),
    .init_done_o (init_done)
  );

  // No request is taken while the clearing pass runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_ready_o |-> init_done)
    else $error("request accepted during clearing pass");

  // The hop count never exceeds its saturation value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o |-> (hops_o <= HOPS_MAX))
    else $error("hop count above saturation");

  // A query hit carries no insert information.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && found_o) |-> (hops_o == '0 && !status_o))
    else $error("hit result with insert fields set");

  // A full table report always counts at least one slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && status_o) |-> (hops_o != '0))
    else $error("full report without hops");

endmodule
